// File: design/coordinated_move_speed_planner_core_macros.svh
// ----------------------------------------------------------------------------
// Coordinated move speed planner: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef COORDINATED_MOVE_SPEED_PLANNER_CORE_MACROS_SVH
`define COORDINATED_MOVE_SPEED_PLANNER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle, reset masked
`define CMSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cmsp implication check failed");

// expression holds on every clock out of reset
`define CMSP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("cmsp invariant check failed");

`endif

// File: design/cmsp_pkg.sv
// ----------------------------------------------------------------------------
// Coordinated move speed planner: package
// Widths, register indexes and transfer types shared by all planner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cmsp_pkg;

  localparam int AXES         = 3;
  localparam int POS_W        = 32;
  localparam int SPD_W        = 16;
  localparam int DELTA_W      = POS_W + 1;
  localparam int DEN_W        = POS_W;
  localparam int Q_W          = SPD_W;
  localparam int NUM_W        = DEN_W + Q_W;
  localparam int DIV_STAGES   = Q_W;
  localparam int FRONT_STAGES = 4;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_SPEED = 3'd3;

  localparam logic [SPD_W-1:0] MIN_SPEED_RESET = 16'd10;

  typedef struct packed {
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic signed [POS_W-1:0] target_z;
    logic signed [POS_W-1:0] now_x;
    logic signed [POS_W-1:0] now_y;
    logic signed [POS_W-1:0] now_z;
    logic        [SPD_W-1:0] vector_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] machine_x;
    logic signed [POS_W-1:0] machine_y;
    logic signed [POS_W-1:0] machine_z;
    logic        [SPD_W-1:0] rate_x;
    logic        [SPD_W-1:0] rate_y;
    logic        [SPD_W-1:0] rate_z;
    logic                    go_x;
    logic                    go_y;
    logic                    go_z;
    logic                    null_move;
  } out_item_t;

  typedef struct packed {
    logic [AXES-1:0][POS_W-1:0] offset;
    logic [SPD_W-1:0]           min_speed;
  } cfg_t;

  typedef struct packed {
    logic [AXES-1:0][POS_W-1:0] mach;
    logic [AXES-1:0]            go;
    logic                       null_move;
  } side_t;

  typedef struct packed {
    logic [AXES-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]           den;
    side_t                      side;
  } div_req_t;

  typedef struct packed {
    logic [AXES-1:0][Q_W-1:0] quo;
    side_t                    side;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: design/coordinated_move_speed_planner_core.sv
// ----------------------------------------------------------------------------
// Coordinated move speed planner core
// Plans one three-axis linear move per transfer: machine targets, per-axis
// step rates scaled to the dominant axis, move flags and a null-move flag.
// ----------------------------------------------------------------------------
// Accepts one move every clock; busy stays low. Each result, strobed by
// out_valid for one cycle, in order, passes through four front-end stages
// (offset, delta, magnitude, dominant count and products), a 16-stage
// restoring divider producing one quotient bit per stage, and the output
// register. The receiver cannot stall. Configuration writes are taken at
// any time (cfg_ready is high) and must be done only while no move is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module coordinated_move_speed_planner_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire cmsp_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  output cmsp_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cmsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cmsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cmsp_pkg::*;

  cfg_t      cfg;
  logic      front_valid;
  div_req_t  front_req;
  logic      div_valid;
  div_rsp_t  div_rsp;

  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  cmsp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cmsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_item   (in_data),
    .cfg       (cfg),
    .out_valid (front_valid),
    .out_req   (front_req)
  );

  cmsp_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_req    (front_req),
    .out_valid (div_valid),
    .out_rsp   (div_rsp)
  );

  always_comb begin
    logic [AXES-1:0][SPD_W-1:0] rate;
    for (int a = 0; a < AXES; a++) begin
      priority if (div_rsp.side.null_move) begin
        rate[a] = '0;
      end else if (!div_rsp.side.go[a] || (div_rsp.quo[a] < cfg.min_speed)) begin
        rate[a] = cfg.min_speed;
      end else begin
        rate[a] = div_rsp.quo[a];
      end
    end
    out_data_nxt.machine_x = div_rsp.side.mach[0];
    out_data_nxt.machine_y = div_rsp.side.mach[1];
    out_data_nxt.machine_z = div_rsp.side.mach[2];
    out_data_nxt.rate_x    = rate[0];
    out_data_nxt.rate_y    = rate[1];
    out_data_nxt.rate_z    = rate[2];
    out_data_nxt.go_x      = div_rsp.side.go[0];
    out_data_nxt.go_y      = div_rsp.side.go[1];
    out_data_nxt.go_z      = div_rsp.side.go[2];
    out_data_nxt.null_move = div_rsp.side.null_move;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: design/cmsp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Coordinated move speed planner: configuration registers
// Work offsets per axis and minimum step rate, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module cmsp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [cmsp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [cmsp_pkg::CFG_DATA_W-1:0] wr_data,
  output cmsp_pkg::cfg_t                       cfg
);
  import cmsp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_IDX_OFFSET_X:  cfg_nxt.offset[0] = wr_data[POS_W-1:0];
        CFG_IDX_OFFSET_Y:  cfg_nxt.offset[1] = wr_data[POS_W-1:0];
        CFG_IDX_OFFSET_Z:  cfg_nxt.offset[2] = wr_data[POS_W-1:0];
        CFG_IDX_MIN_SPEED: cfg_nxt.min_speed = wr_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset    <= '0;
      cfg_r.min_speed <= MIN_SPEED_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: design/cmsp_front.sv
// ----------------------------------------------------------------------------
// Coordinated move speed planner: geometry front end
// Four stages: machine target, 33-bit delta, magnitude, dominant count and
// speed products.
// ----------------------------------------------------------------------------
`default_nettype none

module cmsp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire cmsp_pkg::in_item_t in_item,
  input  wire cmsp_pkg::cfg_t     cfg,
  output logic                    out_valid,
  output cmsp_pkg::div_req_t      out_req
);
  import cmsp_pkg::*;

  logic [AXES-1:0][POS_W-1:0] target;
  logic [AXES-1:0][POS_W-1:0] now;

  assign target[0] = in_item.target_x;
  assign target[1] = in_item.target_y;
  assign target[2] = in_item.target_z;
  assign now[0]    = in_item.now_x;
  assign now[1]    = in_item.now_y;
  assign now[2]    = in_item.now_z;

  // stage A: machine target
  logic                       va_r;
  logic [AXES-1:0][POS_W-1:0] mach_a_r;
  logic [AXES-1:0][POS_W-1:0] now_a_r;
  logic [SPD_W-1:0]           spd_a_r;

  // stage B: signed delta
  logic                         vb_r;
  logic [AXES-1:0][POS_W-1:0]   mach_b_r;
  logic [AXES-1:0][DELTA_W-1:0] delta_b_r;
  logic [SPD_W-1:0]             spd_b_r;

  // stage C: magnitude
  logic                       vc_r;
  logic [AXES-1:0][POS_W-1:0] mach_c_r;
  logic [AXES-1:0][POS_W-1:0] mag_c_r;
  logic [SPD_W-1:0]           spd_c_r;

  // stage D: dominant count and products
  logic     vd_r;
  div_req_t req_d_r;
  div_req_t req_d_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      mach_a_r[a]  <= target[a] - cfg.offset[a];
      now_a_r[a]   <= now[a];
      delta_b_r[a] <= {mach_a_r[a][POS_W-1], mach_a_r[a]} - {now_a_r[a][POS_W-1], now_a_r[a]};
      mag_c_r[a]   <= delta_b_r[a][DELTA_W-1] ? POS_W'(-delta_b_r[a]) : delta_b_r[a][POS_W-1:0];
    end
    spd_a_r  <= in_item.vector_speed;
    mach_b_r <= mach_a_r;
    spd_b_r  <= spd_a_r;
    mach_c_r <= mach_b_r;
    spd_c_r  <= spd_b_r;
    req_d_r  <= req_d_nxt;
  end

  always_comb begin
    logic [POS_W-1:0] big_xy;
    big_xy            = (mag_c_r[1] > mag_c_r[0]) ? mag_c_r[1] : mag_c_r[0];
    req_d_nxt.den     = (mag_c_r[2] > big_xy) ? mag_c_r[2] : big_xy;
    req_d_nxt.side.mach = mach_c_r;
    for (int a = 0; a < AXES; a++) begin
      req_d_nxt.num[a]     = {{Q_W{1'b0}}, mag_c_r[a]} * {{DEN_W{1'b0}}, spd_c_r};
      req_d_nxt.side.go[a] = |mag_c_r[a];
    end
    req_d_nxt.side.null_move = ~|req_d_nxt.side.go;
  end

  assign out_valid = vd_r;
  assign out_req   = req_d_r;

endmodule

`default_nettype wire

// File: design/cmsp_div_pipe.sv
// ----------------------------------------------------------------------------
// Coordinated move speed planner: pipelined divider
// Restoring division, one quotient bit per stage, one lane per axis.
// The quotient fits Q_W bits because each numerator is below den << Q_W.
// ----------------------------------------------------------------------------
`default_nettype none

module cmsp_div_pipe (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire cmsp_pkg::div_req_t in_req,
  output logic                    out_valid,
  output cmsp_pkg::div_rsp_t      out_rsp
);
  import cmsp_pkg::*;

  logic [DIV_STAGES-1:0]      vld_r;
  logic [AXES-1:0][DEN_W-1:0] rem_r [DIV_STAGES];
  logic [AXES-1:0][Q_W-1:0]   shf_r [DIV_STAGES];
  logic [DEN_W-1:0]           den_r [DIV_STAGES];
  side_t                      side_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                       vld_in;
    logic [AXES-1:0][DEN_W-1:0] rem_in;
    logic [AXES-1:0][Q_W-1:0]   shf_in;
    logic [DEN_W-1:0]           den_in;
    side_t                      side_in;
    logic [AXES-1:0][DEN_W-1:0] rem_nxt;
    logic [AXES-1:0][Q_W-1:0]   shf_nxt;

    if (s == 0) begin : g_src
      always_comb begin
        vld_in  = in_valid;
        den_in  = in_req.den;
        side_in = in_req.side;
        for (int a = 0; a < AXES; a++) begin
          rem_in[a] = in_req.num[a][NUM_W-1:Q_W];
          shf_in[a] = in_req.num[a][Q_W-1:0];
        end
      end
    end else begin : g_src
      always_comb begin
        vld_in  = vld_r[s-1];
        den_in  = den_r[s-1];
        side_in = side_r[s-1];
        rem_in  = rem_r[s-1];
        shf_in  = shf_r[s-1];
      end
    end

    always_comb begin
      logic [DEN_W:0] trial;
      for (int a = 0; a < AXES; a++) begin
        trial = {rem_in[a], shf_in[a][Q_W-1]};
        if (trial >= {1'b0, den_in}) begin
          rem_nxt[a] = DEN_W'(trial - {1'b0, den_in});
          shf_nxt[a] = {shf_in[a][Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[a] = trial[DEN_W-1:0];
          shf_nxt[a] = {shf_in[a][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      shf_r[s]  <= shf_nxt;
      den_r[s]  <= den_in;
      side_r[s] <= side_in;
    end
  end

  assign out_valid    = vld_r[DIV_STAGES-1];
  assign out_rsp.quo  = shf_r[DIV_STAGES-1];
  assign out_rsp.side = side_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: design/cmsp_checker.sv
// ----------------------------------------------------------------------------
// Coordinated move speed planner: port checker
// Watches the top-level ports for latency and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coordinated_move_speed_planner_core_macros.svh"

module cmsp_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire cmsp_pkg::out_item_t  out_data
);
  import cmsp_pkg::*;

  logic rates_zero;
  logic any_go;

  assign rates_zero = (out_data.rate_x == '0) && (out_data.rate_y == '0) &&
                      (out_data.rate_z == '0);
  assign any_go     = out_data.go_x || out_data.go_y || out_data.go_z;

  `CMSP_ASSERT_IMPLY(a_result_has_start, clk, rst_n, out_valid, $past(start && !busy, LATENCY))
  `CMSP_ASSERT_IMPLY(a_null_is_still, clk, rst_n, out_valid && out_data.null_move, rates_zero && !any_go)
  `CMSP_ASSERT_IMPLY(a_real_move_moves, clk, rst_n, out_valid && !out_data.null_move, any_go)
  `CMSP_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

endmodule

bind coordinated_move_speed_planner_core cmsp_checker u_cmsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
